// ===== design/dhp_pkg.sv =====
// Package for the diff hunk header parser.
// Holds the parse phase, hunk kind and record status codes and the byte constants.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package dhp_pkg;

	// Position within a header line.
	typedef enum logic [2:0] {
		PH_START,
		PH_A,
		PH_B,
		PH_C,
		PH_D
	} phase_t;

	// Kind byte of a header.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ADD,
		KIND_CHANGE,
		KIND_DELETE
	} kind_t;

	// Status of a result record.
	typedef enum logic [1:0] {
		ST_HUNK       = 2'd0,
		ST_END        = 2'd1,
		ST_FORMAT_ERR = 2'd2,
		ST_ORDER_ERR  = 2'd3
	} status_t;

	localparam int unsigned COUNT_BITS = 31;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;

endpackage

`default_nettype wire

// ===== design/dhp_channels.sv =====
// Valid/ready channel interfaces for the diff hunk header parser.
// The text channel carries one byte or the end flag; the result channel carries one record.
// Uses dhp_pkg for the width of the hunk count.
`default_nettype none

interface dhp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface dhp_result_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      status;
	logic [31:0]                     old_first;
	logic [31:0]                     old_past_end;
	logic [31:0]                     new_first;
	logic [31:0]                     new_past_end;
	logic [dhp_pkg::COUNT_BITS-1:0]  hunks_seen;

	modport source (output valid, output status, output old_first, output old_past_end,
		output new_first, output new_past_end, output hunks_seen, input ready);
	modport sink   (input valid, input status, input old_first, input old_past_end,
		input new_first, input new_past_end, input hunks_seen, output ready);
endinterface

`default_nettype wire

// ===== design/diff_hunk_header_parser.sv =====
// Top level of the diff hunk header parser: input register, parse logic, result register.
// Depends on dhp_pkg and the channel interfaces in dhp_channels.sv.
//
// The block reads normal-format diff text one byte per cycle and turns each header line
// (a[,b]kind c[,d]) into half-open old and new ranges, checked for inversion and order.
// It takes a new byte every cycle, also while a record waits on the result channel, as long
// as the result register can drain; a byte is held in the input register, its record in the
// result register. The rate is set by the parse state feedback: the times-ten accumulate with
// its overflow test, and the range compares on the line end, sit between the input register
// and the state registers. After an end or error record all further bytes are consumed with
// no result until reset. The carriage return option may only be changed while idle.
`default_nettype none

module diff_hunk_header_parser #(
	parameter int unsigned NUMBER_BITS = 31
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_write_enable,
	input  wire              cfg_write_data,
	dhp_text_if.sink         text_in,
	dhp_result_if.source     result_out
);

	localparam int unsigned NB = NUMBER_BITS;

	typedef logic [NB-1:0] num_t;
	typedef logic [NB:0]   wide_t;
	typedef logic [NB+3:0] prod_t;
	typedef logic [dhp_pkg::COUNT_BITS-1:0] count_t;

	// Configuration register.
	logic strip_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Parse state.
	dhp_pkg::phase_t phase_q, phase_n;
	dhp_pkg::kind_t  kind_q, kind_n;
	logic   skip_q, skip_n;
	logic   digits_q, digits_n;
	logic   pending_q, pending_n;
	logic   halted_q, halted_n;
	num_t   first_q, first_n;
	num_t   second_q, second_n;
	num_t   third_q, third_n;
	num_t   fourth_q, fourth_n;
	wide_t  prev_old_q, prev_old_n;
	wide_t  prev_new_q, prev_new_n;
	count_t total_q, total_n;

	// Result register.
	logic                 out_valid_q;
	dhp_pkg::status_t     status_q;
	logic [31:0]          old_first_q, old_past_end_q, new_first_q, new_past_end_q;
	count_t               hunks_q;

	// Result of the current byte.
	logic             res_valid;
	dhp_pkg::status_t res_status;
	logic [31:0]      res_old_first, res_old_past, res_new_first, res_new_past;
	count_t           res_count;

	logic   advance, take;
	logic   is_digit, do_finish;
	logic [3:0] digit_val;
	num_t   acc, acc_next, fourth_eff;
	prod_t  acc_ext, prod;
	logic   overflow;
	wide_t  fin_a, fin_b, fin_c, fin_d;
	count_t total_inc;

	// Handshake: the input register moves on whenever the result register can take a record.
	assign advance       = !out_valid_q || result_out.ready;
	assign take          = valid_s1 && advance;
	assign text_in.ready = !valid_s1 || advance;

	// Byte classification.
	always_comb begin
		is_digit  = byte_s1 inside {[dhp_pkg::CH_ZERO:dhp_pkg::CH_NINE]};
		digit_val = 4'(byte_s1 - dhp_pkg::CH_ZERO);
	end

	// Decimal accumulate of the field selected by the phase, with overflow detection.
	always_comb begin
		case (phase_q)
			dhp_pkg::PH_A: acc = first_q;
			dhp_pkg::PH_B: acc = second_q;
			dhp_pkg::PH_C: acc = third_q;
			dhp_pkg::PH_D: acc = fourth_q;
			default:       acc = first_q;
		endcase
		acc_ext  = prod_t'(acc);
		prod     = (acc_ext << 3) + (acc_ext << 1) + prod_t'(digit_val);
		overflow = |prod[NB+3:NB];
		acc_next = prod[NB-1:0];
	end

	// Range ends of a completed header; in phase C the second new number equals the first.
	always_comb begin
		fourth_eff = (phase_q == dhp_pkg::PH_C) ? third_q : fourth_q;
		fin_a = wide_t'(first_q) + wide_t'(kind_q == dhp_pkg::KIND_ADD);
		fin_b = wide_t'(second_q) + wide_t'(1'b1);
		fin_c = wide_t'(third_q) + wide_t'(kind_q == dhp_pkg::KIND_DELETE);
		fin_d = wide_t'(fourth_eff) + wide_t'(1'b1);
		total_inc = (total_q != dhp_pkg::COUNT_MAX) ? total_q + count_t'(1) : total_q;
	end

	// Next parse state and the record for the byte in the input register.
	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		skip_n     = skip_q;
		digits_n   = digits_q;
		pending_n  = pending_q;
		halted_n   = halted_q;
		first_n    = first_q;
		second_n   = second_q;
		third_n    = third_q;
		fourth_n   = fourth_q;
		prev_old_n = prev_old_q;
		prev_new_n = prev_new_q;
		total_n    = total_q;
		res_valid     = 1'b0;
		res_status    = dhp_pkg::ST_FORMAT_ERR;
		res_old_first = '0;
		res_old_past  = '0;
		res_new_first = '0;
		res_new_past  = '0;
		res_count     = total_q;
		do_finish     = 1'b0;

		if (halted_q) begin
			// Everything is consumed silently until reset.
		end else if (eot_s1) begin
			res_valid = 1'b1;
			halted_n  = 1'b1;
			if (phase_q == dhp_pkg::PH_START) begin
				res_status    = dhp_pkg::ST_END;
				res_old_first = 32'(prev_old_q);
				res_old_past  = 32'(prev_old_q);
				res_new_first = 32'(prev_new_q);
				res_new_past  = 32'(prev_new_q);
			end
		end else if (pending_q) begin
			if (byte_s1 == dhp_pkg::CH_LF) begin
				do_finish = 1'b1;
			end else begin
				res_valid = 1'b1;
				halted_n  = 1'b1;
			end
		end else begin
			case (phase_q)
				dhp_pkg::PH_START: begin
					if (skip_q) begin
						if (byte_s1 == dhp_pkg::CH_LF) skip_n = 1'b0;
					end else if (is_digit) begin
						first_n = num_t'(digit_val);
						phase_n = dhp_pkg::PH_A;
					end else if (byte_s1 != dhp_pkg::CH_LF) begin
						skip_n = 1'b1;
					end
				end
				dhp_pkg::PH_A, dhp_pkg::PH_B: begin
					if (is_digit) begin
						if (phase_q == dhp_pkg::PH_B && !digits_q) begin
							second_n = num_t'(digit_val);
							digits_n = 1'b1;
						end else if (overflow) begin
							res_valid = 1'b1;
							halted_n  = 1'b1;
						end else if (phase_q == dhp_pkg::PH_A) begin
							first_n = acc_next;
						end else begin
							second_n = acc_next;
						end
					end else if (phase_q == dhp_pkg::PH_A && byte_s1 == dhp_pkg::CH_COMMA) begin
						phase_n  = dhp_pkg::PH_B;
						digits_n = 1'b0;
					end else if ((phase_q == dhp_pkg::PH_B && !digits_q) ||
						!(byte_s1 inside {dhp_pkg::CH_A, dhp_pkg::CH_C, dhp_pkg::CH_D})) begin
						res_valid = 1'b1;
						halted_n  = 1'b1;
					end else begin
						if (phase_q == dhp_pkg::PH_A) second_n = first_q;
						case (byte_s1)
							dhp_pkg::CH_A: kind_n = dhp_pkg::KIND_ADD;
							dhp_pkg::CH_D: kind_n = dhp_pkg::KIND_DELETE;
							default:       kind_n = dhp_pkg::KIND_CHANGE;
						endcase
						phase_n  = dhp_pkg::PH_C;
						digits_n = 1'b0;
					end
				end
				default: begin
					if (is_digit) begin
						if (!digits_q) begin
							digits_n = 1'b1;
							if (phase_q == dhp_pkg::PH_C) third_n = num_t'(digit_val);
							else fourth_n = num_t'(digit_val);
						end else if (overflow) begin
							res_valid = 1'b1;
							halted_n  = 1'b1;
						end else if (phase_q == dhp_pkg::PH_C) begin
							third_n = acc_next;
						end else begin
							fourth_n = acc_next;
						end
					end else if (!digits_q) begin
						res_valid = 1'b1;
						halted_n  = 1'b1;
					end else if (phase_q == dhp_pkg::PH_C && byte_s1 == dhp_pkg::CH_COMMA) begin
						phase_n  = dhp_pkg::PH_D;
						digits_n = 1'b0;
					end else begin
						if (phase_q == dhp_pkg::PH_C) fourth_n = third_q;
						if (byte_s1 == dhp_pkg::CH_LF) begin
							do_finish = 1'b1;
						end else if (byte_s1 == dhp_pkg::CH_CR && strip_q) begin
							pending_n = 1'b1;
						end else begin
							res_valid = 1'b1;
							halted_n  = 1'b1;
						end
					end
				end
			endcase
		end

		// Line end of a header: check the ranges and emit the hunk record, or an error record on a failed check.
		if (do_finish) begin
			phase_n   = dhp_pkg::PH_START;
			pending_n = 1'b0;
			res_valid = 1'b1;
			if (fin_b < fin_a || fin_d < fin_c) begin
				halted_n = 1'b1;
			end else if (fin_a < prev_old_q || fin_c < prev_new_q) begin
				res_status = dhp_pkg::ST_ORDER_ERR;
				halted_n   = 1'b1;
			end else begin
				res_status    = dhp_pkg::ST_HUNK;
				res_old_first = 32'(fin_a);
				res_old_past  = 32'(fin_b);
				res_new_first = 32'(fin_c);
				res_new_past  = 32'(fin_d);
				res_count     = total_inc;
				prev_old_n    = fin_b;
				prev_new_n    = fin_d;
				total_n       = total_inc;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b0;
		end else if (cfg_write_enable) begin
			strip_q <= cfg_write_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			eot_s1  <= text_in.end_of_text;
		end
	end

	// Parse state registers with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dhp_pkg::PH_START;
			kind_q     <= dhp_pkg::KIND_NONE;
			skip_q     <= 1'b0;
			digits_q   <= 1'b0;
			pending_q  <= 1'b0;
			halted_q   <= 1'b0;
			prev_old_q <= '0;
			prev_new_q <= '0;
			total_q    <= '0;
		end else if (take) begin
			phase_q    <= phase_n;
			kind_q     <= kind_n;
			skip_q     <= skip_n;
			digits_q   <= digits_n;
			pending_q  <= pending_n;
			halted_q   <= halted_n;
			prev_old_q <= prev_old_n;
			prev_new_q <= prev_new_n;
			total_q    <= total_n;
		end
	end

	// Number fields: always written before they are read.
	always_ff @(posedge clk) begin
		if (take) begin
			first_q  <= first_n;
			second_q <= second_n;
			third_q  <= third_n;
			fourth_q <= fourth_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			status_q       <= res_status;
			old_first_q    <= res_old_first;
			old_past_end_q <= res_old_past;
			new_first_q    <= res_new_first;
			new_past_end_q <= res_new_past;
			hunks_q        <= res_count;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.status       = status_q;
	assign result_out.old_first    = old_first_q;
	assign result_out.old_past_end = old_past_end_q;
	assign result_out.new_first    = new_first_q;
	assign result_out.new_past_end = new_past_end_q;
	assign result_out.hunks_seen   = hunks_q;

endmodule

`default_nettype wire

// ===== design/dhp_checker.sv =====
// Port-level checks for the diff hunk header parser, and the bind that attaches them.
// Depends on dhp_pkg for the status codes; sees only the result channel of the top level.
`default_nettype none

module dhp_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire [1:0]                      status,
	input wire [31:0]                     old_first,
	input wire [31:0]                     old_past_end,
	input wire [31:0]                     new_first,
	input wire [31:0]                     new_past_end,
	input wire [dhp_pkg::COUNT_BITS-1:0]  hunks_seen
);

	// A stalled record holds its status, its old and new first numbers and its count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(old_first) &&
			$stable(new_first) && $stable(hunks_seen))
		else $error("result record changed while stalled");

	// Once an end or error record has been taken nothing follows it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status != dhp_pkg::ST_HUNK |=> !out_valid)
		else $error("record after end or error record");

	// Error records carry empty ranges.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dhp_pkg::ST_FORMAT_ERR || status == dhp_pkg::ST_ORDER_ERR) |->
			old_first == 32'd0 && old_past_end == 32'd0 && new_first == 32'd0 &&
			new_past_end == 32'd0)
		else $error("error record with nonzero range");

	// The end record carries the sentinel as empty ranges.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dhp_pkg::ST_END |->
			old_first == old_past_end && new_first == new_past_end)
		else $error("end record sentinel mismatch");

	// A hunk record counts itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dhp_pkg::ST_HUNK |-> hunks_seen != '0)
		else $error("hunk record with zero count");

endmodule

bind diff_hunk_header_parser dhp_checker u_dhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.status       (result_out.status),
	.old_first    (result_out.old_first),
	.old_past_end (result_out.old_past_end),
	.new_first    (result_out.new_first),
	.new_past_end (result_out.new_past_end),
	.hunks_seen   (result_out.hunks_seen)
);

`default_nettype wire
